// ===== rtl/rei_pkg.sv =====
// Shared types and constants for the ray / ellipsoid intersection unit.
// No dependencies; imported by the front, back and top-level modules (not by rei_fifo).
`default_nettype none

package rei_pkg;

    // Request modes
    localparam logic [1:0] MODE_EXIT   = 2'd0;
    localparam logic [1:0] MODE_ENTRY  = 2'd1;
    localparam logic [1:0] MODE_INSIDE = 2'd2;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_INV_SQ_X = 2'd0;
    localparam logic [1:0] REG_INV_SQ_Y = 2'd1;
    localparam logic [1:0] REG_INV_SQ_Z = 2'd2;

    localparam logic [31:0] INV_SQ_RESET = 32'h0100_0000;

    // Datapath widths
    localparam int A_W    = 44;   // a = sum u^2 k, units 2^-32
    localparam int BM_W   = 59;   // |b|
    localparam int CM_W   = 72;   // |c|
    localparam int D_W    = 120;  // discriminant, units 2^-64
    localparam int ROOT_W = D_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int N_W    = 62;   // signed numerator
    localparam int M_W    = N_W - 1;
    localparam int DIVR_W = A_W + 1;
    localparam int Q_W    = 31;
    localparam int FRAC_W = 16;

    localparam int SQ_STEPS  = ROOT_W;
    localparam int DIV_STEPS = Q_W;

    localparam logic [97:0] ONE_P = 98'd1 << 56;
    localparam logic [30:0] T_MAX = 31'h7FFF_FFFF;

    // Per-item data that travels past the coefficient stages
    typedef struct packed {
        logic [1:0]      mode;
        logic [30:0]     len;
        logic            is_inside;
        logic [A_W-1:0]  a;
        logic            bneg;
        logic [BM_W-1:0] bm;
    } t_meta;

    // Entry of the queue between front and back
    typedef struct packed {
        t_meta          meta;
        logic           dpos;
        logic [D_W-1:0] d;
    } t_mid;

    // Result beat
    typedef struct packed {
        logic        flag;
        logic [30:0] distance;
    } t_res;

endpackage

`default_nettype wire

// ===== rtl/rei_fifo.sv =====
// Small flop-based FIFO used between front and back and at the output.
// No package dependencies.
`default_nettype none

module rei_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_rd,
    output logic      [WIDTH-1:0] o_rdata,
    output logic                  o_empty,
    output logic                  o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             wr_en;
    logic             rd_en;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    // Store beat
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd_en) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_empty_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> (r_wp == r_rp)) else $error("fifo empty with pointers apart");
    a_full_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> (r_wp == r_rp)) else $error("fifo full with pointers apart");
    a_cnt_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && !rd_en) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("fifo count did not rise");
    a_cnt_dn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en && !wr_en) |=> (r_cnt == $past(r_cnt) - 1'b1))
        else $error("fifo count did not fall");
`endif

endmodule

`default_nettype wire

// ===== rtl/rei_front.sv =====
// Front pipeline: accepts rays, forms a, b, c and the discriminant.
// Depends on rei_pkg.
`default_nettype none

module rei_front
    import rei_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic        [1:0]  i_req_type,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic signed [17:0] i_dir_x,
    input  wire logic signed [17:0] i_dir_y,
    input  wire logic signed [17:0] i_dir_z,
    input  wire logic        [30:0] i_seg_len,
    input  wire logic [2:0][31:0]   i_inv_sq,
    output logic                    o_mid_valid,
    output t_mid                    o_mid,
    input  wire logic               i_mid_full
);

    localparam int STAGES = 9;

    logic [STAGES-1:0] r_fv;
    logic              adv;

    logic [2:0][31:0] w_pos;
    logic [2:0][17:0] w_dir;
    logic [2:0][31:0] n_ru;
    logic [2:0][17:0] n_uu;

    logic [3:0][1:0]  r_mode;
    logic [3:0][30:0] r_len;

    logic [2:0][63:0] r1_rr;
    logic [2:0][49:0] r1_ru;
    logic [2:0][35:0] r1_uu;
    logic [2:0]       r1_sg;

    logic [2:0][63:0] r2_rrl, r2_rrh, r2_rul, r2_uul;
    logic [2:0][49:0] r2_ruh;
    logic [2:0][35:0] r2_uuh;
    logic [2:0]       r2_sg;

    logic [2:0][95:0] r3_p;
    logic [2:0][81:0] r3_tb;
    logic [2:0][67:0] r3_ta;
    logic [2:0]       r3_sg;

    logic [97:0]        r4_p;
    logic [69:0]        r4_a;
    logic signed [84:0] r4_b;
    logic signed [84:0] n4_b;

    logic [84:0] n5_bmag;
    logic [97:0] n5_cmag;
    logic        n5_cneg;
    t_meta       r5_meta;
    logic [CM_W-1:0] r5_cm;
    logic        r5_cneg;

    logic [1:0][2:0][45:0] r6_pa;
    logic [59:0] r6_b00;
    logic [58:0] r6_b01;
    logic [57:0] r6_b11;
    t_meta       r6_meta;
    logic        r6_cneg;

    logic [94:0]    r7_aca, r7_acb;
    logic [D_W-1:0] r7_bb;
    t_meta          r7_meta;
    logic           r7_cneg;

    logic [D_W-1:0] r8_ac, r8_bb;
    t_meta          r8_meta;
    logic           r8_cneg;

    logic [D_W:0]   n9_sum, n9_diff;
    logic [D_W-1:0] n9_d;
    logic           n9_dpos;
    t_mid           r9_mid;

    // Whole pipe moves when its tail can drain
    assign adv         = !r_fv[STAGES-1] || !i_mid_full;
    assign o_in_ready  = adv;
    assign o_mid_valid = r_fv[STAGES-1];
    assign o_mid       = r9_mid;

    assign w_pos = {i_pos_z, i_pos_y, i_pos_x};
    assign w_dir = {i_dir_z, i_dir_y, i_dir_x};

    // Magnitudes of point and direction
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_ru[i] = w_pos[i][31] ? (~w_pos[i] + 32'd1) : w_pos[i];
            n_uu[i] = w_dir[i][17] ? (~w_dir[i] + 18'd1) : w_dir[i];
        end
    end

    // Signed sum of the cross terms
    always_comb begin
        n4_b = '0;
        for (int i = 0; i < 3; i++) begin
            n4_b = r3_sg[i] ? (n4_b - $signed(85'(r3_tb[i])))
                            : (n4_b + $signed(85'(r3_tb[i])));
        end
    end

    // Magnitudes of b and c, inside test
    always_comb begin
        n5_bmag = r4_b[84] ? 85'(-r4_b) : 85'(r4_b);
        n5_cneg = (r4_p < ONE_P);
        n5_cmag = n5_cneg ? (ONE_P - r4_p) : (r4_p - ONE_P);
    end

    // Discriminant with sign of c folded in
    always_comb begin
        n9_sum  = {1'b0, r8_bb} + {1'b0, r8_ac};
        n9_diff = {1'b0, r8_bb} - {1'b0, r8_ac};
        if (r8_cneg) begin
            n9_d    = n9_sum[D_W-1:0];
            n9_dpos = |n9_sum;
        end else if (!n9_diff[D_W] && (|n9_diff[D_W-1:0])) begin
            n9_d    = n9_diff[D_W-1:0];
            n9_dpos = 1'b1;
        end else begin
            n9_d    = '0;
            n9_dpos = 1'b0;
        end
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (adv) begin
            r_fv <= {r_fv[STAGES-2:0], i_in_valid};
        end
    end

    // Datapath stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mode <= {r_mode[2:0], i_req_type};
            r_len  <= {r_len[2:0], i_seg_len};

            // 1: squares and cross products
            for (int i = 0; i < 3; i++) begin
                r1_rr[i] <= 64'(n_ru[i]) * 64'(n_ru[i]);
                r1_ru[i] <= 50'(n_ru[i]) * 50'(n_uu[i]);
                r1_uu[i] <= 36'(n_uu[i]) * 36'(n_uu[i]);
                r1_sg[i] <= w_pos[i][31] ^ w_dir[i][17];
            end

            // 2: scale by 1/s^2 in 32-bit slices
            for (int i = 0; i < 3; i++) begin
                r2_rrl[i] <= 64'(r1_rr[i][31:0])  * 64'(i_inv_sq[i]);
                r2_rrh[i] <= 64'(r1_rr[i][63:32]) * 64'(i_inv_sq[i]);
                r2_rul[i] <= 64'(r1_ru[i][31:0])  * 64'(i_inv_sq[i]);
                r2_ruh[i] <= 50'(r1_ru[i][49:32]) * 50'(i_inv_sq[i]);
                r2_uul[i] <= 64'(r1_uu[i][31:0])  * 64'(i_inv_sq[i]);
                r2_uuh[i] <= 36'(r1_uu[i][35:32]) * 36'(i_inv_sq[i]);
                r2_sg[i]  <= r1_sg[i];
            end

            // 3: join slices per axis
            for (int i = 0; i < 3; i++) begin
                r3_p[i]  <= 96'(r2_rrl[i]) + {r2_rrh[i], 32'd0};
                r3_tb[i] <= 82'(r2_rul[i]) + {r2_ruh[i], 32'd0};
                r3_ta[i] <= 68'(r2_uul[i]) + {r2_uuh[i], 32'd0};
                r3_sg[i] <= r2_sg[i];
            end

            // 4: sum over axes
            r4_p <= 98'(r3_p[0]) + 98'(r3_p[1]) + 98'(r3_p[2]);
            r4_a <= 70'(r3_ta[0]) + 70'(r3_ta[1]) + 70'(r3_ta[2]);
            r4_b <= n4_b;

            // 5: truncate to units 2^-32
            r5_meta.mode      <= r_mode[3];
            r5_meta.len       <= r_len[3];
            r5_meta.is_inside <= (r4_p <= ONE_P);
            r5_meta.a         <= r4_a[67:24];
            r5_meta.bneg      <= r4_b[84];
            r5_meta.bm        <= n5_bmag[82:24];
            r5_cm             <= n5_cmag[95:24];
            r5_cneg           <= n5_cneg;

            // 6: partial products of a*c and b*b
            for (int i = 0; i < 2; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r6_pa[i][j] <= 46'(r5_meta.a[i*22 +: 22]) * 46'(r5_cm[j*24 +: 24]);
                end
            end
            r6_b00  <= 60'(r5_meta.bm[29:0])  * 60'(r5_meta.bm[29:0]);
            r6_b01  <= 59'(r5_meta.bm[29:0])  * 59'(r5_meta.bm[58:30]);
            r6_b11  <= 58'(r5_meta.bm[58:30]) * 58'(r5_meta.bm[58:30]);
            r6_meta <= r5_meta;
            r6_cneg <= r5_cneg;

            // 7: partial sums
            r7_aca  <= 95'(r6_pa[0][0]) + (95'(r6_pa[0][1]) << 24)
                     + (95'(r6_pa[0][2]) << 48);
            r7_acb  <= 95'(r6_pa[1][0]) + (95'(r6_pa[1][1]) << 24)
                     + (95'(r6_pa[1][2]) << 48);
            r7_bb   <= D_W'(r6_b00) + (D_W'(r6_b01) << 31) + (D_W'(r6_b11) << 60);
            r7_meta <= r6_meta;
            r7_cneg <= r6_cneg;

            // 8: full a*c
            r8_ac   <= D_W'(r7_aca) + (D_W'(r7_acb) << 22);
            r8_bb   <= r7_bb;
            r8_meta <= r7_meta;
            r8_cneg <= r7_cneg;

            // 9: discriminant
            r9_mid.meta <= r8_meta;
            r9_mid.d    <= n9_d;
            r9_mid.dpos <= n9_dpos;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rei_back.sv =====
// Back pipeline: square root, quotient and result selection.
// Depends on rei_pkg.
`default_nettype none

module rei_back
    import rei_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_mid_valid,
    output logic      o_mid_pop,
    input  wire t_mid i_mid,
    output logic      o_res_valid,
    output t_res      o_res,
    input  wire logic i_res_full
);

    localparam int STAGES = SQ_STEPS + DIV_STEPS + 3;

    typedef struct packed {
        t_meta             meta;
        logic              dpos;
        logic [D_W-1:0]    d;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sq;

    typedef struct packed {
        t_meta          meta;
        logic           dpos;
        logic           nneg;
        logic [M_W-1:0] m;
    } t_nm;

    typedef struct packed {
        t_meta             meta;
        logic              dpos;
        logic              nneg;
        logic              sat;
        logic [DIVR_W-1:0] r;
        logic [Q_W-1:0]    q;
        logic [Q_W-1:0]    nb;
    } t_dv;

    // One root digit: bring down two bits, try 4*root+1
    function automatic t_sq f_sq_step(input t_sq s);
        t_sq              o;
        logic [REM_W+1:0] w;
        logic [REM_W+1:0] tr;
        o  = s;
        w  = {s.rem, s.d[D_W-1 -: 2]};
        tr = {2'b00, s.root, 2'b01};
        if (w >= tr) begin
            o.rem  = REM_W'(w - tr);
            o.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            o.rem  = w[REM_W-1:0];
            o.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        o.d = {s.d[D_W-3:0], 2'b00};
        return o;
    endfunction

    // One quotient bit, restoring
    function automatic t_dv f_dv_step(input t_dv s);
        t_dv               o;
        logic [DIVR_W-1:0] w;
        o = s;
        w = {s.r[DIVR_W-2:0], s.nb[Q_W-1]};
        if (w >= DIVR_W'(s.meta.a)) begin
            o.r = w - DIVR_W'(s.meta.a);
            o.q = {s.q[Q_W-2:0], 1'b1};
        end else begin
            o.r = w;
            o.q = {s.q[Q_W-2:0], 1'b0};
        end
        o.nb = {s.nb[Q_W-2:0], 1'b0};
        return o;
    endfunction

    logic [STAGES-1:0] r_bv;
    logic              adv;
    logic              take;

    t_sq  n_sq0;
    t_sq  r_sq [SQ_STEPS];
    t_nm  n_nm;
    t_nm  r_nm;
    t_dv  n_pr;
    t_dv  r_pr;
    t_dv  r_dv [DIV_STEPS];
    t_res n_res;
    t_res r_res;

    logic [N_W-1:0] nm_negb;
    logic [N_W-1:0] nm_n;
    logic [Q_W-1:0] fin_t;
    logic           fin_pos;
    logic           fin_azero;

    assign adv         = !r_bv[STAGES-1] || !i_res_full;
    assign take        = adv && i_mid_valid;
    assign o_mid_pop   = take;
    assign o_res_valid = r_bv[STAGES-1];
    assign o_res       = r_res;

    // Seed the root pipe
    always_comb begin
        n_sq0      = '0;
        n_sq0.meta = i_mid.meta;
        n_sq0.dpos = i_mid.dpos;
        n_sq0.d    = i_mid.d;
    end

    // Numerator -b +/- sqrt(D), sign and magnitude
    always_comb begin
        t_sq s;
        s       = r_sq[SQ_STEPS-1];
        nm_negb = s.meta.bneg ? N_W'(s.meta.bm) : N_W'(-N_W'(s.meta.bm));
        nm_n    = (s.meta.mode == MODE_EXIT) ? (nm_negb + N_W'(s.root))
                                             : (nm_negb - N_W'(s.root));
        n_nm.meta = s.meta;
        n_nm.dpos = s.dpos;
        n_nm.nneg = nm_n[N_W-1];
        n_nm.m    = nm_n[N_W-1] ? M_W'(-nm_n) : nm_n[M_W-1:0];
    end

    // Overflow check and divider seed
    always_comb begin
        n_pr.meta = r_nm.meta;
        n_pr.dpos = r_nm.dpos;
        n_pr.nneg = r_nm.nneg;
        n_pr.sat  = (r_nm.m >= {2'b00, r_nm.meta.a, 15'd0});
        n_pr.r    = r_nm.m[M_W-2:15];
        n_pr.q    = '0;
        n_pr.nb   = {r_nm.m[14:0], 16'd0};
    end

    // Pick flag and distance by mode
    always_comb begin
        t_dv s;
        s         = r_dv[DIV_STEPS-1];
        fin_t     = s.sat ? T_MAX : s.q;
        fin_pos   = !s.nneg && (fin_t != '0);
        fin_azero = (s.meta.a == '0);
        n_res     = '0;
        case (s.meta.mode)
            MODE_EXIT: begin
                if (fin_azero) begin
                    n_res.distance = T_MAX;
                end else begin
                    n_res.flag = (s.nneg && (fin_t != '0)) || (fin_t < s.meta.len);
                    n_res.distance = fin_pos ? fin_t : '0;
                end
            end
            MODE_ENTRY: begin
                if (s.dpos && !fin_azero && fin_pos) begin
                    n_res.flag     = (fin_t < s.meta.len);
                    n_res.distance = fin_t;
                end
            end
            MODE_INSIDE: begin
                n_res.flag = s.meta.is_inside;
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
        end else if (adv) begin
            r_bv <= {r_bv[STAGES-2:0], take};
        end
    end

    // Advance datapath
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq[0] <= f_sq_step(n_sq0);
            for (int j = 1; j < SQ_STEPS; j++) begin
                r_sq[j] <= f_sq_step(r_sq[j-1]);
            end
            r_nm    <= n_nm;
            r_pr    <= n_pr;
            r_dv[0] <= f_dv_step(r_pr);
            for (int j = 1; j < DIV_STEPS; j++) begin
                r_dv[j] <= f_dv_step(r_dv[j-1]);
            end
            r_res <= n_res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ray_ellipsoid_intersect_unit.sv =====
// Ray / axis-aligned ellipsoid intersection unit: one ray per clock cycle in steady state
// when nothing stalls, through 9 front stages, 94 back stages and the two queues. Most of
// the depth is in the back pipeline: a 60-stage digit-by-digit square root of the 120-bit
// discriminant followed by a 31-stage restoring divider, each stage retiring one digit.
// The front forms a, b, c and the discriminant in nine stages; a short queue sits between
// front and back and another at the result side, so a stalled consumer holds the back
// while the front keeps filling. The three 1/s^2 registers must only be written while no
// ray is in flight.
// Top level; depends on rei_pkg, rei_fifo, rei_front, rei_back.
`default_nettype none

module ray_ellipsoid_intersect_unit
    import rei_pkg::*;
#(
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // ray queue side
    input  wire logic               push,
    output logic                    full,
    input  wire logic        [1:0]  i_req_type,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic signed [17:0] i_dir_x,
    input  wire logic signed [17:0] i_dir_y,
    input  wire logic signed [17:0] i_dir_z,
    input  wire logic        [30:0] i_seg_len,
    // result queue side
    output logic                    empty,
    input  wire logic               pop,
    output logic                    o_flag,
    output logic             [30:0] o_distance,
    // register port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic        [3:0]  paddr,
    input  wire logic        [31:0] pwdata,
    output logic             [31:0] prdata,
    output logic                    pready
);

    logic [31:0] r_inv_sq_x;
    logic [31:0] r_inv_sq_y;
    logic [31:0] r_inv_sq_z;
    logic [2:0][31:0] w_inv_sq;

    logic front_ready;
    logic mid_valid;
    t_mid mid_wdata;
    logic mid_full;
    logic mid_empty;
    logic [$bits(t_mid)-1:0] mid_rdata;
    logic mid_pop;

    logic res_valid;
    t_res res_wdata;
    logic res_full;
    logic [$bits(t_res)-1:0] res_rdata;
    t_res res_head;

    assign pready   = 1'b1;
    assign w_inv_sq = {r_inv_sq_z, r_inv_sq_y, r_inv_sq_x};

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_sq_x <= INV_SQ_RESET;
            r_inv_sq_y <= INV_SQ_RESET;
            r_inv_sq_z <= INV_SQ_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_INV_SQ_X: r_inv_sq_x <= pwdata;
                REG_INV_SQ_Y: r_inv_sq_y <= pwdata;
                REG_INV_SQ_Z: r_inv_sq_z <= pwdata;
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (paddr[3:2])
            REG_INV_SQ_X: prdata = r_inv_sq_x;
            REG_INV_SQ_Y: prdata = r_inv_sq_y;
            REG_INV_SQ_Z: prdata = r_inv_sq_z;
            default:      prdata = '0;
        endcase
    end

    assign full = !front_ready;

    rei_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (push),
        .o_in_ready (front_ready),
        .i_req_type (i_req_type),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_pos_z    (i_pos_z),
        .i_dir_x    (i_dir_x),
        .i_dir_y    (i_dir_y),
        .i_dir_z    (i_dir_z),
        .i_seg_len  (i_seg_len),
        .i_inv_sq   (w_inv_sq),
        .o_mid_valid(mid_valid),
        .o_mid      (mid_wdata),
        .i_mid_full (mid_full)
    );

    rei_fifo #(
        .WIDTH($bits(t_mid)),
        .DEPTH(MID_DEPTH)
    ) u_mid_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (mid_valid),
        .i_wdata(mid_wdata),
        .i_rd   (mid_pop),
        .o_rdata(mid_rdata),
        .o_empty(mid_empty),
        .o_full (mid_full)
    );

    rei_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mid_valid(!mid_empty),
        .o_mid_pop  (mid_pop),
        .i_mid      (t_mid'(mid_rdata)),
        .o_res_valid(res_valid),
        .o_res      (res_wdata),
        .i_res_full (res_full)
    );

    rei_fifo #(
        .WIDTH($bits(t_res)),
        .DEPTH(OUT_DEPTH)
    ) u_out_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (res_valid),
        .i_wdata(res_wdata),
        .i_rd   (pop),
        .o_rdata(res_rdata),
        .o_empty(empty),
        .o_full (res_full)
    );

    assign res_head   = t_res'(res_rdata);
    assign o_flag     = res_head.flag;
    assign o_distance = res_head.distance;

endmodule

`default_nettype wire
